// ===== design/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

    // Number of slots in the store.
    localparam int SLOT_COUNT = 1024;
    // Width of a slot index.
    localparam int IDX_W = $clog2(SLOT_COUNT);
    // Width of a count that can hold SLOT_COUNT itself.
    localparam int CNT_W = IDX_W + 1;
    // Width of a generation.
    localparam int GEN_W = 32;

    // Request kinds.
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_STALE    = 2'd2,
        ST_CAPACITY = 2'd3
    } status_t;

    // One slot entry as it sits in the slot memory.
    typedef struct packed {
        logic             alive;
        logic [CNT_W-1:0] link;
        logic [GEN_W-1:0] gen;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // Command bundle from the core to the slot memory.
    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        slot_entry_t      wdata;
    } ram_cmd_t;

    // One result item.
    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] slot_index;
        logic [GEN_W-1:0] generation;
        logic             alive;
        logic [CNT_W-1:0] live_count;
        logic [CNT_W-1:0] used_slots;
        logic [CNT_W-1:0] free_slots;
    } rsp_t;

endpackage

// ===== design/gha_req_if.sv =====
// ----------------------------------------------------------------------------
// gha_req_if
// Request channel: valid, ready and one request item.
// ----------------------------------------------------------------------------
interface gha_req_if;

    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [gha_pkg::IDX_W-1:0] slot_index;
    logic [gha_pkg::GEN_W-1:0] generation;

    modport source (output valid, kind, slot_index, generation, input ready);
    modport sink   (input valid, kind, slot_index, generation, output ready);

endinterface

// ===== design/gha_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gha_rsp_if
// Result channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface gha_rsp_if;

    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [gha_pkg::IDX_W-1:0] out_slot_index;
    logic [gha_pkg::GEN_W-1:0] out_generation;
    logic                      alive;
    logic [gha_pkg::CNT_W-1:0] live_count;
    logic [gha_pkg::CNT_W-1:0] used_slots;
    logic [gha_pkg::CNT_W-1:0] free_slots;

    modport source (output valid, status, out_slot_index, out_generation, alive,
                    live_count, used_slots, free_slots, input ready);
    modport sink   (input valid, status, out_slot_index, out_generation, alive,
                    live_count, used_slots, free_slots, output ready);

endinterface

// ===== design/gha_ram.sv =====
// ----------------------------------------------------------------------------
// gha_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/gha_core.sv =====
// ----------------------------------------------------------------------------
// gha_core
// Request sequencer: reads the slot entry, decides the result, writes the
// entry back and keeps the free-list head and the slot counters.
// ----------------------------------------------------------------------------
module gha_core (
    input  logic                 clk,
    input  logic                 rst_n,
    gha_req_if.sink              req,
    input  gha_pkg::slot_entry_t ram_rdata,
    output gha_pkg::ram_cmd_t    ram_cmd,
    input  logic                 rsp_free,
    output logic                 rsp_load,
    output gha_pkg::rsp_t        rsp_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [1:0]                kind_reg;
    logic [gha_pkg::IDX_W-1:0] idx_reg;
    logic [gha_pkg::GEN_W-1:0] gen_reg;
    logic [gha_pkg::CNT_W-1:0] free_head_reg, free_head_next;
    logic [gha_pkg::CNT_W-1:0] high_water_reg, high_water_next;
    logic [gha_pkg::CNT_W-1:0] live_total_reg, live_total_next;
    logic [gha_pkg::CNT_W-1:0] free_total_reg, free_total_next;

    logic                      req_fire;
    logic                      commit;
    logic                      null_handle;
    logic                      idx_used;
    logic                      gen_match;
    logic                      list_pop;
    logic [gha_pkg::GEN_W-1:0] gen_bumped;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign commit    = (state_reg == S_EXEC) && rsp_free;
    assign rsp_load  = commit;

    // State sequencing: S_IDLE takes an item and issues its read, S_EXEC finishes it once the result register is free.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_head_reg  <= gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT);
            high_water_reg <= '0;
            live_total_reg <= '0;
            free_total_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            high_water_reg <= high_water_next;
            live_total_reg <= live_total_next;
            free_total_reg <= free_total_next;
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg <= req.kind;
            idx_reg  <= req.slot_index;
            gen_reg  <= req.generation;
        end
    end

    // Decode of the request against the entry read back.
    assign null_handle = (idx_reg == '0) && (gen_reg == '0);
    assign idx_used    = ({1'b0, idx_reg} < high_water_reg);
    assign gen_match   = ram_rdata.alive && (ram_rdata.gen == gen_reg);
    assign list_pop    = (free_total_reg != '0) &&
                         (free_head_reg < gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT));
    assign gen_bumped  = ((ram_rdata.gen + 1'b1) == '0) ? gha_pkg::GEN_W'(1)
                                                        : ram_rdata.gen + 1'b1;

    // Read issue, result, write-back and counter updates, applied on commit.
    always_comb
    begin
        // An allocate reads the free-list head, others their slot.
        ram_cmd.re = req_fire;
        if (req.kind == gha_pkg::KIND_ALLOC)
        begin
            ram_cmd.raddr = free_head_reg[gha_pkg::IDX_W-1:0];
        end
        else
        begin
            ram_cmd.raddr = req.slot_index;
        end

        free_head_next  = free_head_reg;
        high_water_next = high_water_reg;
        live_total_next = live_total_reg;
        free_total_next = free_total_reg;
        ram_cmd.we      = 1'b0;
        ram_cmd.waddr   = idx_reg;
        ram_cmd.wdata   = ram_rdata;
        rsp_data.status     = gha_pkg::ST_OK;
        rsp_data.slot_index = '0;
        rsp_data.generation = '0;
        rsp_data.alive      = 1'b0;

        case (kind_reg)
            gha_pkg::KIND_ALLOC:
            begin
                if (list_pop)
                begin
                    ram_cmd.we          = commit;
                    ram_cmd.waddr       = free_head_reg[gha_pkg::IDX_W-1:0];
                    ram_cmd.wdata.alive = 1'b1;
                    ram_cmd.wdata.link  = gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT);
                    ram_cmd.wdata.gen   = ram_rdata.gen;
                    free_head_next      = ram_rdata.link;
                    free_total_next     = free_total_reg - 1'b1;
                    live_total_next     = live_total_reg + 1'b1;
                    rsp_data.slot_index = free_head_reg[gha_pkg::IDX_W-1:0];
                    rsp_data.generation = ram_rdata.gen;
                end
                else if (high_water_reg >= gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT))
                begin
                    rsp_data.status = gha_pkg::ST_CAPACITY;
                end
                else
                begin
                    ram_cmd.we          = commit;
                    ram_cmd.waddr       = high_water_reg[gha_pkg::IDX_W-1:0];
                    ram_cmd.wdata.alive = 1'b1;
                    ram_cmd.wdata.link  = gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT);
                    ram_cmd.wdata.gen   = gha_pkg::GEN_W'(1);
                    high_water_next     = high_water_reg + 1'b1;
                    live_total_next     = live_total_reg + 1'b1;
                    rsp_data.slot_index = high_water_reg[gha_pkg::IDX_W-1:0];
                    rsp_data.generation = gha_pkg::GEN_W'(1);
                end
            end
            gha_pkg::KIND_FREE:
            begin
                if (null_handle)
                begin
                    rsp_data.status = gha_pkg::ST_INVALID;
                end
                else if (!idx_used || !gen_match)
                begin
                    rsp_data.status = gha_pkg::ST_STALE;
                end
                else
                begin
                    ram_cmd.we          = commit;
                    ram_cmd.wdata.alive = 1'b0;
                    ram_cmd.wdata.link  = free_head_reg;
                    ram_cmd.wdata.gen   = gen_bumped;
                    free_head_next      = {1'b0, idx_reg};
                    free_total_next     = free_total_reg + 1'b1;
                    if (live_total_reg != '0)
                    begin
                        live_total_next = live_total_reg - 1'b1;
                    end
                end
            end
            gha_pkg::KIND_QUERY:
            begin
                if (null_handle)
                begin
                    rsp_data.status = gha_pkg::ST_INVALID;
                end
                else
                begin
                    rsp_data.alive = idx_used && gen_match;
                end
            end
            default:
            begin
                rsp_data.status = gha_pkg::ST_INVALID;
            end
        endcase

        // Counters move only when the item is handed to the output stage.
        if (!commit)
        begin
            free_head_next  = free_head_reg;
            high_water_next = high_water_reg;
            live_total_next = live_total_reg;
            free_total_next = free_total_reg;
        end

        rsp_data.live_count = live_total_next;
        rsp_data.used_slots = high_water_next;
        rsp_data.free_slots = free_total_next;
    end

`ifndef SYNTHESIS
    // Every slot ever handed out is either live or on the free list.
    assert property (@(posedge clk) disable iff (!rst_n)
        live_total_reg + free_total_reg == high_water_reg)
        else $error("live and free counts do not add up to the high-water mark");

    // The free-list head is the empty sentinel exactly when the list is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (free_total_reg == '0) ==
        (free_head_reg == gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT)))
        else $error("free-list head disagrees with the free count");

    // The high-water mark never passes the store size.
    assert property (@(posedge clk) disable iff (!rst_n)
        high_water_reg <= gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT))
        else $error("high-water mark beyond the store size");

    // An accepted item is always followed by its execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter execution");

    // The slot memory is written only in the cycle an item commits.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_cmd.we |-> commit)
        else $error("slot memory written outside a commit");
`endif

endmodule

// ===== design/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out, frees and checks handles made of a slot index and a generation.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Payload
// req       in    kind, slot_index, generation
// rsp       out   status, out_slot_index, out_generation, alive,
//                 live_count, used_slots, free_slots
//
// Each item first reads its slot entry from the slot memory, then decides
// the result and writes the entry back.
// The next item is taken in the cycle after the result is registered.
// The result register lets a new item in while a result waits; a held
// result stalls the core in its execute cycle until it is taken.
// Reset clears the counters and sets the free-list head to the empty sentinel;
// the slot memory is not cleared, since only entries of slots below the high-water mark are used.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
    input  logic      clk,
    input  logic      rst_n,
    gha_req_if.sink   req,
    gha_rsp_if.source rsp
);

    gha_pkg::ram_cmd_t    ram_cmd;
    gha_pkg::slot_entry_t ram_rdata;
    logic [gha_pkg::ENTRY_W-1:0] ram_rdata_raw;
    logic                 rsp_load;
    logic                 rsp_free;
    gha_pkg::rsp_t        rsp_data;
    gha_pkg::rsp_t        rsp_reg;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Slot memory: alive flag, next-free link and generation per slot.
    gha_ram #(
        .WIDTH (gha_pkg::ENTRY_W),
        .DEPTH (gha_pkg::SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .re    (ram_cmd.re),
        .raddr (ram_cmd.raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = gha_pkg::slot_entry_t'(ram_rdata_raw);

    gha_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_rdata (ram_rdata),
        .ram_cmd   (ram_cmd),
        .rsp_free  (rsp_free),
        .rsp_load  (rsp_load),
        .rsp_data  (rsp_data)
    );

    // Result register: free when empty or being taken this cycle.
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_data;
        end
    end

    // Result channel.
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_reg.status;
    assign rsp.out_slot_index = rsp_reg.slot_index;
    assign rsp.out_generation = rsp_reg.generation;
    assign rsp.alive          = rsp_reg.alive;
    assign rsp.live_count     = rsp_reg.live_count;
    assign rsp.used_slots     = rsp_reg.used_slots;
    assign rsp.free_slots     = rsp_reg.free_slots;

endmodule

// ===== tb/gha_result_checker.sv =====
// ----------------------------------------------------------------------------
// gha_result_checker
// Watches both channels of the handle allocator and predicts every result.
// Each accepted request item is run through a slot-map model of the
// allocator, and each accepted result item is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module gha_result_checker (
    input  logic clk,
    input  logic rst_n,
    gha_req_if   req,
    gha_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    import gha_pkg::*;

    // Model of the slot store and its counters.
    logic [GEN_W-1:0] slot_gen  [SLOT_COUNT];
    logic             slot_live [SLOT_COUNT];
    logic [CNT_W-1:0] slot_link [SLOT_COUNT];
    logic [CNT_W-1:0] list_head = CNT_W'(SLOT_COUNT);
    logic [CNT_W-1:0] hwm       = '0;
    logic [CNT_W-1:0] live_n    = '0;
    logic [CNT_W-1:0] free_n    = '0;

    // Predicted results, oldest first.
    rsp_t expected_results[$];
    int   fail_total = 0;

    // Apply one request item to the model and return the result it causes.
    function automatic rsp_t allocator_step(logic [1:0] kind, logic [IDX_W-1:0] idx,
                                            logic [GEN_W-1:0] gen);
        rsp_t             r;
        logic             is_null;
        logic [IDX_W-1:0] s;
        logic [GEN_W-1:0] bumped;
        r = '0;
        r.status = ST_OK;
        is_null = (idx == '0) && (gen == '0);
        case (kind)
            KIND_ALLOC:
            begin
                if (free_n != '0 && list_head < SLOT_COUNT) begin
                    // Reuse the most recently freed slot.
                    s = list_head[IDX_W-1:0];
                    list_head = slot_link[s];
                    free_n = free_n - 1'b1;
                    slot_live[s] = 1'b1;
                    slot_link[s] = CNT_W'(SLOT_COUNT);
                    live_n = live_n + 1'b1;
                    r.slot_index = s;
                    r.generation = slot_gen[s];
                end else if (hwm >= SLOT_COUNT) begin
                    r.status = ST_CAPACITY;
                end else begin
                    // Open a fresh slot at generation 1.
                    s = hwm[IDX_W-1:0];
                    hwm = hwm + 1'b1;
                    slot_live[s] = 1'b1;
                    slot_link[s] = CNT_W'(SLOT_COUNT);
                    slot_gen[s] = GEN_W'(1);
                    live_n = live_n + 1'b1;
                    r.slot_index = s;
                    r.generation = GEN_W'(1);
                end
            end
            KIND_FREE:
            begin
                if (is_null) begin
                    r.status = ST_INVALID;
                end else if (idx >= hwm) begin
                    r.status = ST_STALE;
                end else if (!slot_live[idx] || slot_gen[idx] != gen) begin
                    r.status = ST_STALE;
                end else begin
                    // Retire the handle: bump the generation past zero and push the slot.
                    bumped = slot_gen[idx] + 1'b1;
                    if (bumped == '0) begin
                        bumped = GEN_W'(1);
                    end
                    slot_live[idx] = 1'b0;
                    slot_gen[idx] = bumped;
                    slot_link[idx] = list_head;
                    list_head = CNT_W'(idx);
                    free_n = free_n + 1'b1;
                    if (live_n != '0) begin
                        live_n = live_n - 1'b1;
                    end
                end
            end
            KIND_QUERY:
            begin
                if (is_null) begin
                    r.status = ST_INVALID;
                end else if (idx < hwm) begin
                    r.alive = slot_live[idx] && (slot_gen[idx] == gen);
                end
            end
            default:
            begin
                r.status = ST_INVALID;
            end
        endcase
        r.live_count = live_n;
        r.used_slots = hwm;
        r.free_slots = free_n;
        return r;
    endfunction

    // Compare one field and report it when it differs.
    function automatic void check_field(string name, logic [GEN_W-1:0] want,
                                        logic [GEN_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_total++;
        end
    endfunction

    // Predict on every accepted request item, check every accepted result item.
    always @(posedge clk) begin : watch
        rsp_t want;
        if (rst_n) begin
            if (req.valid && req.ready) begin
                expected_results.push_back(allocator_step(req.kind, req.slot_index,
                                                          req.generation));
            end
            if (rsp.valid && rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0h",
                             $time, rsp.status);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", GEN_W'(want.status), GEN_W'(rsp.status));
                    check_field("out_slot_index", GEN_W'(want.slot_index),
                                GEN_W'(rsp.out_slot_index));
                    check_field("out_generation", want.generation, rsp.out_generation);
                    check_field("alive", GEN_W'(want.alive), GEN_W'(rsp.alive));
                    check_field("live_count", GEN_W'(want.live_count), GEN_W'(rsp.live_count));
                    check_field("used_slots", GEN_W'(want.used_slots), GEN_W'(rsp.used_slots));
                    check_field("free_slots", GEN_W'(want.free_slots), GEN_W'(rsp.free_slots));
                end
            end
        end
        mismatches <= fail_total;
        outstanding <= expected_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the generational handle allocator.
// A directed sequence covers null handles, unknown indexes, stale and
// mismatched handles, free-list reuse and the reserved kind. Random traffic
// then mixes allocations with frees and queries of live, retired and made-up
// handles.
// ----------------------------------------------------------------------------
module tb_top;

    import gha_pkg::*;

    // Request kind that the block rejects.
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    // Cycles without any accepted item before the run is abandoned.
    localparam int STALL_LIMIT = 2000;
    // Number of retired handles kept for stale requests.
    localparam int RETIRED_DEPTH = 64;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
    } handle_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic idle_on = 1'b1;
    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;
    int   ready_burst = 0;

    // Handles seen coming back from allocations, and handles already freed.
    handle_t live_handles[$];
    handle_t retired_handles[$];

    gha_req_if req_ch();
    gha_rsp_if rsp_ch();

    generational_handle_allocator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    gha_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side backpressure: random ready and stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            ready_burst <= 0;
        end
        else if (!idle_on)
        begin
            rsp_ch.ready <= 1'b1;
        end
        else if (ready_burst == 0)
        begin
            if ($urandom_range(2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                ready_burst <= $urandom_range(14, 0);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                ready_burst <= $urandom_range(40, 1);
            end
        end
        else
        begin
            ready_burst <= ready_burst - 1;
        end
    end

    // Collect handles from result items in mid-cycle, when the channel is stable.
    always @(negedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (rsp_ch.status == ST_OK && rsp_ch.out_generation != '0)
            begin
                live_handles.push_back({rsp_ch.out_slot_index, rsp_ch.out_generation});
            end
        end
    end

    // Watchdog on handshake progress.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offer one request item and hold it until it is accepted.
    task automatic send_item(input logic [1:0] k, input logic [IDX_W-1:0] idx,
                             input logic [GEN_W-1:0] g);
        int gap;
        if (k == KIND_FREE)
        begin
            for (int i = live_handles.size() - 1; i >= 0; i--)
            begin
                if (live_handles[i] == {idx, g})
                begin
                    live_handles.delete(i);
                    if (retired_handles.size() >= RETIRED_DEPTH)
                    begin
                        void'(retired_handles.pop_front());
                    end
                    retired_handles.push_back({idx, g});
                end
            end
        end
        if (idle_on && $urandom_range(4) == 0)
        begin
            gap = $urandom_range(15, 1);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= k;
        req_ch.slot_index <= idx;
        req_ch.generation <= g;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // One random request item, mostly aimed at handles the block really issued.
    task automatic random_item();
        int         pick;
        int         n;
        handle_t    h;
        logic [1:0] k;
        pick = $urandom_range(99);
        n = $urandom_range(9);
        h.idx = IDX_W'($urandom_range(SLOT_COUNT - 1));
        h.gen = $urandom();
        if (pick < 35)
        begin
            k = KIND_ALLOC;
        end
        else if (pick < 92)
        begin
            k = (pick < 62) ? KIND_FREE : KIND_QUERY;
            if (n < 6 && live_handles.size() > 0)
            begin
                h = live_handles[$urandom_range(live_handles.size() - 1)];
            end
            else if (n == 6 && live_handles.size() > 0)
            begin
                // Live slot, wrong generation.
                h = live_handles[$urandom_range(live_handles.size() - 1)];
                h.gen = h.gen + 1'b1;
            end
            else if (n < 9 && retired_handles.size() > 0)
            begin
                h = retired_handles[$urandom_range(retired_handles.size() - 1)];
            end
            else if ($urandom_range(1) == 0)
            begin
                // Small generations can land on a real handle or the null handle.
                h.gen = $urandom_range(3);
            end
        end
        else if (pick < 96)
        begin
            k = (pick % 2 == 0) ? KIND_FREE : KIND_QUERY;
            h = '0;
        end
        else
        begin
            k = KIND_RESERVED;
        end
        send_item(k, h.idx, h.gen);
    endtask

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.kind <= KIND_ALLOC;
        req_ch.slot_index <= '0;
        req_ch.generation <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: null handles, never-issued indexes and the reserved kind.
        send_item(KIND_QUERY, '0, '0);
        send_item(KIND_FREE, '0, '0);
        send_item(KIND_FREE, 10'd5, 32'd1);
        send_item(KIND_QUERY, '1, '1);
        send_item(KIND_RESERVED, '0, '0);
        // Fresh slots 0, 1 and 2 at generation 1.
        send_item(KIND_ALLOC, '1, '1);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_ALLOC, 10'h155, 32'hAAAA_5555);
        send_item(KIND_QUERY, '0, 32'd1);
        send_item(KIND_QUERY, 10'd1, 32'd2);
        send_item(KIND_QUERY, '0, '0);
        // Free, double free, wrong generation, query of a dead slot.
        send_item(KIND_FREE, 10'd1, 32'd1);
        send_item(KIND_FREE, 10'd1, 32'd1);
        send_item(KIND_FREE, 10'd2, '1);
        send_item(KIND_QUERY, 10'd1, 32'd1);
        send_item(KIND_ALLOC, '0, '0);
        // The free list hands slots back last in, first out.
        send_item(KIND_FREE, '0, 32'd1);
        send_item(KIND_FREE, 10'd2, 32'd1);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_QUERY, 10'd3, 32'd1);
        send_item(KIND_QUERY, '0, 32'd2);
        send_item(KIND_RESERVED, '1, '1);

        // Random traffic with a small store.
        repeat (280) random_item();

        // More random traffic as the store grows.
        repeat (450) random_item();

        // Closing stretch at full rate on both sides.
        idle_on <= 1'b0;
        repeat (100) random_item();
        req_ch.valid <= 1'b0;

        // Drain the outstanding results, then allow for the block's latency.
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== generational_handle_allocator.f =====
design/gha_pkg.sv
design/gha_req_if.sv
design/gha_rsp_if.sv
design/gha_ram.sv
design/gha_core.sv
design/generational_handle_allocator.sv
tb/gha_result_checker.sv
tb/tb_top.sv
